>>> sv/csv_field_splitter_unit_macros.svh
// Assertion macros used by the top level of the CSV field splitter RTL.
`ifndef CSV_FIELD_SPLITTER_UNIT_MACROS_SVH
`define CSV_FIELD_SPLITTER_UNIT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, checked out of reset.
`define CSVFS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("csvfs: same-cycle check failed");
// Next-cycle implication, checked out of reset.
`define CSVFS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("csvfs: next-cycle check failed");
`else
`define CSVFS_ASSERT_IMP(lbl, ante, cons)
`define CSVFS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> sv/csvfs_pkg.sv
// Package with widths, character codes, result kinds and control types of the CSV splitter.
`timescale 1ns / 1ps
`default_nettype none
package csvfs_pkg;

    localparam int unsigned FIELD_CAPACITY_DEF = 32;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned KIND_W = 3;
    localparam int unsigned LEN_W  = 6;
    localparam int unsigned ROW_W  = 16;
    localparam int unsigned LINE_W = 16;
    localparam int unsigned COL_W  = 10;

    localparam logic [BYTE_W-1:0] SEP_RESET = 8'd44;
    localparam logic [BYTE_W-1:0] CH_QUOTE  = 8'h22;
    localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
    localparam logic [BYTE_W-1:0] CH_HASH   = 8'h23;
    localparam logic [BYTE_W-1:0] CH_NL     = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_SPACE  = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB    = 8'h09;

    localparam logic [ROW_W-1:0]  ROW_MAX  = 16'hFFFF;
    localparam logic [LINE_W-1:0] LINE_MAX = 16'hFFFF;
    localparam logic [COL_W-1:0]  COL_MAX  = 10'd1023;
    localparam logic [ROW_W-1:0]  ROW_ONE  = 16'd1;
    localparam logic [LINE_W-1:0] LINE_ONE = 16'd1;
    localparam logic [COL_W-1:0]  COL_ONE  = 10'd1;

    typedef logic [KIND_W-1:0] csvfs_kind_t;

    localparam csvfs_kind_t KIND_BYTE     = 3'd0;
    localparam csvfs_kind_t KIND_EMPTY    = 3'd1;
    localparam csvfs_kind_t KIND_OVERFLOW = 3'd2;
    localparam csvfs_kind_t KIND_END_OK   = 3'd3;
    localparam csvfs_kind_t KIND_END_BAD  = 3'd4;

    typedef logic [1:0] csvfs_act_t;

    localparam csvfs_act_t ACT_NONE   = 2'd0;
    localparam csvfs_act_t ACT_SINGLE = 2'd1;
    localparam csvfs_act_t ACT_DRAIN  = 2'd2;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic emit_byte;
    } csvfs_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        csvfs_act_t act;
        logic       drain_last;
    } csvfs_stat_t;

endpackage
`default_nettype wire

>>> sv/csvfs_ifs.sv
// Channel interfaces of the CSV splitter: text input, result output and configuration.
`timescale 1ns / 1ps
`default_nettype none
interface csvfs_text_if;
    import csvfs_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] in_byte;
    logic              end_of_input;
    modport source (output valid, output in_byte, output end_of_input, input ready);
    modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

interface csvfs_result_if;
    import csvfs_pkg::*;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] field_byte;
    logic [LEN_W-1:0]  field_length;
    logic [ROW_W-1:0]  row_number;
    logic [LINE_W-1:0] line_number;
    logic [COL_W-1:0]  column_number;
    logic              last;
    modport source (output valid, output kind, output field_byte, output field_length,
                    output row_number, output line_number, output column_number,
                    output last, input ready);
    modport sink (input valid, input kind, input field_byte, input field_length,
                  input row_number, input line_number, input column_number,
                  input last, output ready);
endinterface

interface csvfs_cfg_if;
    import csvfs_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] field_separator;
    modport source (output valid, output field_separator, input ready);
    modport sink (input valid, input field_separator, output ready);
endinterface
`default_nettype wire

>>> sv/csv_field_splitter_unit.sv
// Top level of the CSV field splitter: controller, datapath and assertions.
//
// Usage:
//   text   - request channel carrying one byte of CSV text (in_byte) or an
//            end marker (end_of_input). A byte that is kept, dropped or that
//            gives a single result (empty field, overflow) is done in the idle state.
//   result - one request per result item; the last result caused by an
//            input request has last set.
//   cfg    - writes the field separator; always ready, write it only while
//            the block is idle.
// A single result is registered and appears in the cycle after its input
// request is accepted. A finished field is read out of the field buffer RAM
// byte by byte: a read state gives the address and the RAM registers the
// data, then an emit state loads it into the result register, waiting while
// the receiver stalls; no new text is taken during that drain.
// Reset clears the parse state and counters (row, line and column to one),
// sets the separator to comma and leaves the field buffer contents as they
// were. When the receiver stalls, the result register holds its request
// and no text is taken until that request has been accepted.
`timescale 1ns / 1ps
`default_nettype none
`include "csv_field_splitter_unit_macros.svh"
module csv_field_splitter_unit #(
    parameter int unsigned FIELD_CAPACITY = csvfs_pkg::FIELD_CAPACITY_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    csvfs_text_if.sink      text,
    csvfs_result_if.source  result,
    csvfs_cfg_if.sink       cfg
);
    import csvfs_pkg::*;

    csvfs_cmd_t  cmd;
    csvfs_stat_t stat;
    logic        end_take;
    logic        drain_take;
    logic        end_result;
    logic        byte_result;

    // The separator register accepts a write in every cycle.
    assign cfg.ready = 1'b1;

    csvfs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (text.valid),
        .in_ready  (text.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    csvfs_dp #(
        .FIELD_CAPACITY (FIELD_CAPACITY)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .in_byte       (text.in_byte),
        .end_of_input  (text.end_of_input),
        .cfg_we        (cfg.valid),
        .cfg_separator (cfg.field_separator),
        .kind          (result.kind),
        .field_byte    (result.field_byte),
        .field_length  (result.field_length),
        .row_number    (result.row_number),
        .line_number   (result.line_number),
        .column_number (result.column_number),
        .last          (result.last)
    );

    // Shorthands for the checks below.
    assign end_take    = cmd.take && text.end_of_input;
    assign drain_take  = cmd.take && (stat.act == ACT_DRAIN);
    assign end_result  = result.valid && result.last &&
                         ((result.kind == KIND_END_OK) || (result.kind == KIND_END_BAD));
    assign byte_result = result.valid && (result.kind == KIND_BYTE);

    // An end marker request produces its status result in the next cycle.
    `CSVFS_ASSERT_NXT(a_end_reports, end_take, end_result)

    // Starting a drain closes the text channel in the following cycle.
    `CSVFS_ASSERT_NXT(a_drain_blocks_text, drain_take, !text.ready)

    // No text is taken while a field byte is being emitted.
    `CSVFS_ASSERT_IMP(a_emit_excludes_take, cmd.emit_byte, !cmd.take)

    // A field byte always belongs to a field with at least one byte.
    `CSVFS_ASSERT_IMP(a_byte_has_length, byte_result, result.field_length != '0)

endmodule
`default_nettype wire

>>> sv/csvfs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module csvfs_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 32
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;
endmodule
`default_nettype wire

>>> sv/csvfs_dp.sv
// Datapath of the CSV splitter: parse state, counters, field buffer and result register.
`timescale 1ns / 1ps
`default_nettype none
module csvfs_dp #(
    parameter int unsigned FIELD_CAPACITY = csvfs_pkg::FIELD_CAPACITY_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  csvfs_pkg::csvfs_cmd_t           cmd,
    output csvfs_pkg::csvfs_stat_t          stat,
    input  logic [csvfs_pkg::BYTE_W-1:0]    in_byte,
    input  logic                            end_of_input,
    input  logic                            cfg_we,
    input  logic [csvfs_pkg::BYTE_W-1:0]    cfg_separator,
    output logic [csvfs_pkg::KIND_W-1:0]    kind,
    output logic [csvfs_pkg::BYTE_W-1:0]    field_byte,
    output logic [csvfs_pkg::LEN_W-1:0]     field_length,
    output logic [csvfs_pkg::ROW_W-1:0]     row_number,
    output logic [csvfs_pkg::LINE_W-1:0]    line_number,
    output logic [csvfs_pkg::COL_W-1:0]     column_number,
    output logic                            last
);
    import csvfs_pkg::*;

    localparam int unsigned ADDR_W = (FIELD_CAPACITY > 1) ? $clog2(FIELD_CAPACITY) : 1;
    localparam logic [LEN_W-1:0] CAP = LEN_W'(FIELD_CAPACITY);

    localparam logic [2:0] ST_START   = 3'd0;
    localparam logic [2:0] ST_INSTR   = 3'd1;
    localparam logic [2:0] ST_ESC     = 3'd2;
    localparam logic [2:0] ST_MAYBEDQ = 3'd3;
    localparam logic [2:0] ST_DQ      = 3'd4;
    localparam logic [2:0] ST_COMMENT = 3'd5;

    logic [BYTE_W-1:0] sep_reg;
    logic [2:0]        pstate_reg, pstate_next;
    logic [LEN_W-1:0]  fill_reg, fill_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic              halted_reg, halted_next;
    logic              nl_pend_reg, nl_pend_next;
    logic [LEN_W-1:0]  idx_reg, idx_next;

    logic [KIND_W-1:0] kind_reg;
    logic [BYTE_W-1:0] byte_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [ROW_W-1:0]  row_out_reg;
    logic [LINE_W-1:0] line_out_reg;
    logic [COL_W-1:0]  col_out_reg;
    logic              last_reg;

    logic [2:0]        dec_state;
    logic              want_collect;
    logic              want_end;
    logic              end_nl;
    logic              comment_nl;
    logic              full;
    logic              ram_we;
    logic [BYTE_W-1:0] ram_rdata;
    csvfs_kind_t       single_kind;
    logic [LEN_W-1:0]  single_len;
    logic [ROW_W-1:0]  row_inc;
    logic [LINE_W-1:0] line_inc;
    logic [COL_W-1:0]  col_inc;
    csvfs_act_t        act_sel;
    logic              drain_last;

    // Byte classification per parse state; earlier rules take precedence.
    always_comb
    begin
        dec_state    = pstate_reg;
        want_collect = 1'b0;
        want_end     = 1'b0;
        end_nl       = 1'b0;
        comment_nl   = 1'b0;
        unique case (pstate_reg)
            ST_INSTR:
            begin
                if (in_byte == CH_BSLASH)
                begin
                    dec_state = ST_ESC;
                end
                else if (in_byte == CH_QUOTE)
                begin
                    dec_state = ST_MAYBEDQ;
                end
                else
                begin
                    want_collect = 1'b1;
                end
            end
            ST_ESC:
            begin
                want_collect = 1'b1;
                dec_state    = ST_INSTR;
            end
            ST_MAYBEDQ:
            begin
                if (in_byte == CH_QUOTE)
                begin
                    want_collect = 1'b1;
                    dec_state    = ST_DQ;
                end
                else if (in_byte == CH_NL)
                begin
                    want_end  = 1'b1;
                    end_nl    = 1'b1;
                    dec_state = ST_START;
                end
                else if (in_byte == sep_reg)
                begin
                    want_end  = 1'b1;
                    dec_state = ST_START;
                end
                else
                begin
                    dec_state = ST_INSTR;
                end
            end
            ST_DQ:
            begin
                if (in_byte == CH_QUOTE)
                begin
                    dec_state = ST_START;
                end
                else
                begin
                    want_collect = 1'b1;
                    dec_state    = ST_INSTR;
                end
            end
            ST_COMMENT:
            begin
                if (in_byte == CH_NL)
                begin
                    comment_nl = 1'b1;
                    dec_state  = ST_START;
                end
            end
            default:
            begin
                dec_state = ST_START;
                if (in_byte == CH_QUOTE)
                begin
                    dec_state = ST_INSTR;
                end
                else if ((in_byte == CH_SPACE) || (in_byte == CH_TAB))
                begin
                    dec_state = ST_START;
                end
                else if (in_byte == CH_HASH)
                begin
                    dec_state = ST_COMMENT;
                end
                else if (in_byte == CH_NL)
                begin
                    want_end = 1'b1;
                    end_nl   = 1'b1;
                end
                else if (in_byte == sep_reg)
                begin
                    want_end = 1'b1;
                end
                else
                begin
                    want_collect = 1'b1;
                end
            end
        endcase
    end

    assign full     = (fill_reg >= CAP);
    assign row_inc  = (row_reg < ROW_MAX) ? row_reg + 1'b1 : row_reg;
    assign line_inc = (line_reg < LINE_MAX) ? line_reg + 1'b1 : line_reg;
    assign col_inc  = (col_reg < COL_MAX) ? col_reg + 1'b1 : col_reg;

    // What the current input item produces.
    always_comb
    begin
        act_sel = ACT_NONE;
        if (end_of_input)
        begin
            act_sel = ACT_SINGLE;
        end
        else if (halted_reg)
        begin
            act_sel = ACT_NONE;
        end
        else if (want_collect)
        begin
            act_sel = full ? ACT_SINGLE : ACT_NONE;
        end
        else if (want_end)
        begin
            if (fill_reg != '0)
            begin
                act_sel = ACT_DRAIN;
            end
            else if (!end_nl)
            begin
                act_sel = ACT_SINGLE;
            end
        end
    end

    assign drain_last = (LEN_W'(idx_reg + 1'b1) == fill_reg);

    assign stat.act        = act_sel;
    assign stat.drain_last = drain_last;

    always_comb
    begin
        if (end_of_input)
        begin
            single_kind = (halted_reg || (pstate_reg != ST_START)) ? KIND_END_BAD : KIND_END_OK;
            single_len  = '0;
        end
        else if (want_collect)
        begin
            single_kind = KIND_OVERFLOW;
            single_len  = fill_reg;
        end
        else
        begin
            single_kind = KIND_EMPTY;
            single_len  = '0;
        end
    end

    // State updates for an accepted item and for each drained byte.
    always_comb
    begin
        pstate_next  = pstate_reg;
        fill_next    = fill_reg;
        row_next     = row_reg;
        line_next    = line_reg;
        col_next     = col_reg;
        halted_next  = halted_reg;
        nl_pend_next = nl_pend_reg;
        idx_next     = idx_reg;
        if (cmd.take)
        begin
            if (end_of_input)
            begin
                pstate_next  = ST_START;
                fill_next    = '0;
                row_next     = ROW_ONE;
                line_next    = LINE_ONE;
                col_next     = COL_ONE;
                halted_next  = 1'b0;
                nl_pend_next = 1'b0;
            end
            else if (!halted_reg)
            begin
                if (want_collect && full)
                begin
                    halted_next = 1'b1;
                end
                else
                begin
                    pstate_next = dec_state;
                    if (want_collect)
                    begin
                        fill_next = fill_reg + 1'b1;
                        if ((in_byte == CH_NL) && (pstate_reg == ST_INSTR))
                        begin
                            line_next = line_inc;
                        end
                    end
                    if (want_end)
                    begin
                        if (fill_reg == '0)
                        begin
                            if (!end_nl)
                            begin
                                col_next = col_inc;
                            end
                        end
                        else
                        begin
                            nl_pend_next = end_nl;
                            idx_next     = '0;
                        end
                    end
                    if (comment_nl)
                    begin
                        line_next = line_inc;
                        col_next  = COL_ONE;
                        fill_next = '0;
                    end
                end
            end
        end
        else if (cmd.emit_byte)
        begin
            idx_next = idx_reg + 1'b1;
            if (drain_last)
            begin
                fill_next = '0;
                if (nl_pend_reg)
                begin
                    col_next  = COL_ONE;
                    line_next = line_inc;
                    row_next  = row_inc;
                end
                else
                begin
                    col_next = col_inc;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sep_reg     <= SEP_RESET;
            pstate_reg  <= ST_START;
            fill_reg    <= '0;
            row_reg     <= ROW_ONE;
            line_reg    <= LINE_ONE;
            col_reg     <= COL_ONE;
            halted_reg  <= 1'b0;
            nl_pend_reg <= 1'b0;
            idx_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                sep_reg <= cfg_separator;
            end
            pstate_reg  <= pstate_next;
            fill_reg    <= fill_next;
            row_reg     <= row_next;
            line_reg    <= line_next;
            col_reg     <= col_next;
            halted_reg  <= halted_next;
            nl_pend_reg <= nl_pend_next;
            idx_reg     <= idx_next;
        end
    end

    // Result register; counters are captured before this item moves them.
    always_ff @(posedge clk)
    begin
        if (cmd.take && (act_sel == ACT_SINGLE))
        begin
            kind_reg     <= single_kind;
            byte_reg     <= '0;
            len_reg      <= single_len;
            row_out_reg  <= row_reg;
            line_out_reg <= line_reg;
            col_out_reg  <= col_reg;
            last_reg     <= 1'b1;
        end
        else if (cmd.emit_byte)
        begin
            kind_reg     <= KIND_BYTE;
            byte_reg     <= ram_rdata;
            len_reg      <= fill_reg;
            row_out_reg  <= row_reg;
            line_out_reg <= line_reg;
            col_out_reg  <= col_reg;
            last_reg     <= drain_last;
        end
    end

    assign ram_we = cmd.take && !end_of_input && !halted_reg && want_collect && !full;

    csvfs_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (FIELD_CAPACITY)
    ) u_field_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (fill_reg[ADDR_W-1:0]),
        .wdata (in_byte),
        .raddr (idx_reg[ADDR_W-1:0]),
        .rdata (ram_rdata)
    );

    assign kind          = kind_reg;
    assign field_byte    = byte_reg;
    assign field_length  = len_reg;
    assign row_number    = row_out_reg;
    assign line_number   = line_out_reg;
    assign column_number = col_out_reg;
    assign last          = last_reg;
endmodule
`default_nettype wire

>>> sv/csvfs_ctrl.sv
// Controller of the CSV splitter: input handshake, field drain sequence and result valid.
`timescale 1ns / 1ps
`default_nettype none
module csvfs_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    output logic                    out_valid,
    input  logic                    out_ready,
    output csvfs_pkg::csvfs_cmd_t   cmd,
    input  csvfs_pkg::csvfs_stat_t  stat
);
    import csvfs_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_READ = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;

    assign out_free      = !out_valid_reg || out_ready;
    assign in_ready      = (state_reg == S_IDLE) && out_free;
    assign cmd.take      = in_ready && in_valid;
    assign cmd.emit_byte = (state_reg == S_EMIT) && out_free;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd.take && (stat.act == ACT_DRAIN))
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (cmd.emit_byte)
                begin
                    state_next = stat.drain_last ? S_IDLE : S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if ((cmd.take && (stat.act == ACT_SINGLE)) || cmd.emit_byte)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
endmodule
`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench of the CSV field splitter with a bench model of the parser.
`timescale 1ns / 1ps
module tb;
    import csvfs_pkg::*;

    // Run-length constants. The cycle limit is far above the slowest legal run,
    // in which every field drains a full store past a rarely ready receiver.
    localparam int FIELD_CAP     = FIELD_CAPACITY_DEF;
    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int SETTLE_CYCLES = 8;
    localparam int END_CYCLES    = 2 * FIELD_CAP + 8;
    localparam int RANDOM_ITEMS  = 300;
    localparam int RANDOM_PHASES = 6;
    localparam int MAX_REPORTS   = 200;

    // Parser states of the bench model, numbered as in the block.
    typedef enum logic [2:0] {
        PS_START    = 3'd0,
        PS_STRING   = 3'd1,
        PS_ESCAPE   = 3'd2,
        PS_MAYBE_DQ = 3'd3,
        PS_DOUBLE_Q = 3'd4,
        PS_COMMENT  = 3'd5
    } parse_state_e;

    // One result request as the block should present it.
    typedef struct packed {
        csvfs_kind_t       kind;
        logic [BYTE_W-1:0] field_byte;
        logic [LEN_W-1:0]  field_length;
        logic [ROW_W-1:0]  row_number;
        logic [LINE_W-1:0] line_number;
        logic [COL_W-1:0]  column_number;
        logic              last;
    } field_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always #5 clk = ~clk;

    csvfs_text_if   text_ch();
    csvfs_result_if result_ch();
    csvfs_cfg_if    cfg_ch();

    csv_field_splitter_unit dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .text   (text_ch),
        .result (result_ch),
        .cfg    (cfg_ch)
    );

    // Bench copy of the parser: separator, state, field store and counters.
    logic [BYTE_W-1:0] sep_model;
    parse_state_e      state_model;
    logic [BYTE_W-1:0] field_store [FIELD_CAP];
    int unsigned       fill_model;
    logic [ROW_W-1:0]  row_model;
    logic [LINE_W-1:0] line_model;
    logic [COL_W-1:0]  col_model;
    bit                halted_model;

    // Results of the text request being modeled, and all results still owed.
    field_result_t step_results[$];
    field_result_t pending_results[$];

    int unsigned n_errors = 0;
    int unsigned n_useful_items = 0;
    int unsigned burst_left = 0;
    int unsigned cycle_count = 0;
    bit          bursty = 1'b0;

    // ------------------------------------------------------------------
    // Parser model
    // ------------------------------------------------------------------

    // Return to the post-reset state. The separator is kept: an end marker
    // clears the parser but not the register.
    function automatic void clear_parser();
        state_model  = PS_START;
        fill_model   = 0;
        row_model    = ROW_ONE;
        line_model   = LINE_ONE;
        col_model    = COL_ONE;
        halted_model = 1'b0;
    endfunction

    // Every result carries the counters as they stand before any advance.
    function automatic void note_result(csvfs_kind_t kind, logic [BYTE_W-1:0] value,
                                        int unsigned length);
        field_result_t r;
        r.kind          = kind;
        r.field_byte    = value;
        r.field_length  = LEN_W'(length);
        r.row_number    = row_model;
        r.line_number   = line_model;
        r.column_number = col_model;
        r.last          = 1'b0;
        step_results.push_back(r);
    endfunction

    function automatic void advance_line();
        if (line_model != LINE_MAX)
            line_model++;
    endfunction

    // A separator or newline closes the field. A newline that finds the
    // field empty is swallowed whole: nothing is emitted and no counter moves.
    function automatic void finish_field(bit at_newline);
        if (at_newline && fill_model == 0)
            return;
        if (fill_model == 0)
            note_result(KIND_EMPTY, '0, 0);
        else
            for (int i = 0; i < fill_model; i++)
                note_result(KIND_BYTE, field_store[i], fill_model);
        if (at_newline)
        begin
            col_model = COL_ONE;
            advance_line();
            if (row_model != ROW_MAX)
                row_model++;
        end
        else if (col_model != COL_MAX)
        begin
            col_model++;
        end
        fill_model = 0;
    endfunction

    // Store one byte of the field. A full store turns the byte into an
    // overflow report and halts the parser until the end marker.
    function automatic void keep_byte(logic [BYTE_W-1:0] value);
        if (fill_model >= FIELD_CAP)
        begin
            note_result(KIND_OVERFLOW, '0, fill_model);
            halted_model = 1'b1;
            return;
        end
        // Only a bare newline inside a string counts as a new physical line.
        if (value == CH_NL && state_model == PS_STRING)
            advance_line();
        field_store[fill_model] = value;
        fill_model++;
    endfunction

    // Model one accepted text request and queue the results it causes.
    function automatic void predict_text(logic [BYTE_W-1:0] value, logic eoi);
        parse_state_e  nxt;
        field_result_t r;
        nxt = state_model;
        step_results.delete();
        if (eoi)
        begin
            // The unterminated last field is dropped without a trace.
            note_result((halted_model || state_model != PS_START) ? KIND_END_BAD : KIND_END_OK,
                        '0, 0);
            clear_parser();
        end
        else if (!halted_model)
        begin
            case (state_model)
                PS_STRING:
                begin
                    if (value == CH_BSLASH)
                        nxt = PS_ESCAPE;
                    else if (value == CH_QUOTE)
                        nxt = PS_MAYBE_DQ;
                    else
                        keep_byte(value);
                end
                PS_ESCAPE:
                begin
                    keep_byte(value);
                    nxt = PS_STRING;
                end
                PS_MAYBE_DQ:
                begin
                    // Any other byte after a closing quote is dropped and
                    // the string is reopened.
                    nxt = PS_STRING;
                    if (value == CH_QUOTE)
                    begin
                        keep_byte(value);
                        nxt = PS_DOUBLE_Q;
                    end
                    else if (value == CH_NL)
                    begin
                        finish_field(1'b1);
                        nxt = PS_START;
                    end
                    else if (value == sep_model)
                    begin
                        finish_field(1'b0);
                        nxt = PS_START;
                    end
                end
                PS_DOUBLE_Q:
                begin
                    if (value == CH_QUOTE)
                        nxt = PS_START;
                    else
                    begin
                        keep_byte(value);
                        nxt = PS_STRING;
                    end
                end
                PS_COMMENT:
                begin
                    // The comment's newline throws away the pending field.
                    if (value == CH_NL)
                    begin
                        advance_line();
                        col_model  = COL_ONE;
                        fill_model = 0;
                        nxt        = PS_START;
                    end
                end
                default:
                begin
                    // Rules are tried in this order, so a separator that
                    // equals an earlier byte acts as that byte.
                    nxt = PS_START;
                    if (value == CH_QUOTE)
                        nxt = PS_STRING;
                    else if (value == CH_SPACE || value == CH_TAB)
                    begin
                        // Blanks outside strings are dropped.
                    end
                    else if (value == CH_HASH)
                        nxt = PS_COMMENT;
                    else if (value == CH_NL)
                        finish_field(1'b1);
                    else if (value == sep_model)
                        finish_field(1'b0);
                    else
                        keep_byte(value);
                end
            endcase
            if (!halted_model)
                state_model = nxt;
        end
        foreach (step_results[i])
        begin
            r      = step_results[i];
            r.last = (i == step_results.size() - 1);
            pending_results.push_back(r);
        end
    endfunction

    // ------------------------------------------------------------------
    // Text sender
    // ------------------------------------------------------------------

    // Drive one text request at the falling edge and hold it until the block
    // takes it. In bursty mode the sender idles a random number of cycles
    // between bursts of random length; a gap of zero joins two bursts.
    task automatic send_request(input logic [BYTE_W-1:0] value, input logic eoi);
        int unsigned gap;
        if (bursty)
        begin
            if (burst_left == 0)
            begin
                gap = $urandom_range(0, 6);
                if (gap != 0)
                begin
                    @(negedge clk);
                    text_ch.valid <= 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
                burst_left = $urandom_range(1, 24);
            end
            burst_left--;
        end
        @(negedge clk);
        text_ch.valid        <= 1'b1;
        text_ch.in_byte      <= value;
        text_ch.end_of_input <= eoi;
        do
            @(posedge clk);
        while (!text_ch.ready);
        // Bytes that a halted parser ignores do not count as useful stimulus.
        if (eoi || !halted_model)
            n_useful_items++;
        predict_text(value, eoi);
    endtask

    task automatic send_byte(input logic [BYTE_W-1:0] value);
        send_request(value, 1'b0);
    endtask

    // The byte lane of an end marker is ignored; it gets random content.
    task automatic end_text();
        send_request(BYTE_W'($urandom_range(0, 255)), 1'b1);
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    // Idle the sender until every owed result has arrived, then give the
    // block a few cycles to finish any request that produced no result.
    task automatic settle();
        @(negedge clk);
        text_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        burst_left = 0;
    endtask

    // The separator register is only written with the block idle.
    task automatic write_separator(input logic [BYTE_W-1:0] value);
        settle();
        @(negedge clk);
        cfg_ch.valid           <= 1'b1;
        cfg_ch.field_separator <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        sep_model = value;
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Random CSV text
    // ------------------------------------------------------------------

    // A byte with no meaning to the parser outside a string.
    function automatic logic [BYTE_W-1:0] plain_byte();
        logic [BYTE_W-1:0] v;
        do
            v = BYTE_W'($urandom_range(0, 255));
        while (v == sep_model || v == CH_QUOTE || v == CH_HASH || v == CH_NL ||
               v == CH_SPACE || v == CH_TAB);
        return v;
    endfunction

    // Anything but a quote or a backslash may stand bare inside a string.
    function automatic logic [BYTE_W-1:0] string_byte();
        logic [BYTE_W-1:0] v;
        do
            v = BYTE_W'($urandom_range(0, 255));
        while (v == CH_QUOTE || v == CH_BSLASH);
        return v;
    endfunction

    // Mostly short fields; now and then one near, at or past the store size.
    function automatic int unsigned field_size();
        if ($urandom_range(0, 24) == 0)
            return $urandom_range(FIELD_CAP - 2, FIELD_CAP + 2);
        return $urandom_range(0, 6);
    endfunction

    task automatic send_terminator();
        if ($urandom_range(0, 2) == 0)
            send_byte(CH_NL);
        else
            send_byte(sep_model);
    endtask

    // One random piece of text: a plain field, a quoted field, a comment
    // line, a noise byte or an end marker.
    task automatic send_random_chunk();
        int unsigned pick;
        int unsigned len;
        int unsigned sub;
        // A halted parser only listens for the end marker, so end it soon.
        if (halted_model && $urandom_range(0, 3) == 0)
        begin
            end_text();
            return;
        end
        pick = $urandom_range(0, 99);
        len  = field_size();
        if (pick < 40)
        begin
            if ($urandom_range(0, 4) == 0)
                send_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
            repeat (len) send_byte(plain_byte());
            send_terminator();
        end
        else if (pick < 65)
        begin
            send_byte(CH_QUOTE);
            repeat (len)
            begin
                sub = $urandom_range(0, 9);
                if (sub < 6)
                    send_byte(string_byte());
                else if (sub < 8)
                begin
                    send_byte(CH_BSLASH);
                    send_byte(BYTE_W'($urandom_range(0, 255)));
                end
                else
                begin
                    send_byte(CH_QUOTE);
                    send_byte(CH_QUOTE);
                end
            end
            send_byte(CH_QUOTE);
            send_terminator();
        end
        else if (pick < 73)
        begin
            send_byte(CH_HASH);
            repeat ($urandom_range(0, 5)) send_byte(string_byte() == CH_NL ? 8'h41 : plain_byte());
            send_byte(CH_NL);
        end
        else if (pick < 96)
        begin
            send_byte(BYTE_W'($urandom_range(0, 255)));
        end
        else
        begin
            end_text();
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Plain fields with the default comma: an empty field, a skipped bare
    // newline, dropped blanks, byte zero, 0xFF and a bare backslash as data.
    task automatic test_plain_fields();
        write_separator(SEP_RESET);
        end_text();
        send_string("ab,,\n c\t,");
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(CH_BSLASH);
        send_byte(CH_NL);
        end_text();
    endtask

    // Quoted fields: escapes, newlines in strings, doubled quotes, the byte
    // after a closing quote, and an open string at the end marker.
    task automatic test_quoting();
        send_string("\"a\\\"\n\\\n\"\"x\"\n");
        send_string("\"\",");
        send_string("\"a\"\"\",");
        send_string("\"z\"q\"\n");
        send_string("\"\"\"\n\",");
        send_string("\"u");
        end_text();
    endtask

    // A comment drops the pending field and moves to the next line; an end
    // marker inside a comment is malformed.
    task automatic test_comments();
        send_string("ab#x,\"y\n");
        send_string("c,#\n");
        send_string("#");
        end_text();
    endtask

    // A field that exactly fills the store, then one byte too many: the
    // overflow report, ignored bytes, and a malformed end.
    task automatic test_overflow();
        repeat (FIELD_CAP) send_byte("k");
        send_byte(",");
        repeat (FIELD_CAP + 1) send_byte("m");
        send_string(",n\n");
        end_text();
    endtask

    // Separators at the byte extremes and equal to bytes that earlier rules
    // claim first (space, quote, hash).
    task automatic test_separator_values();
        logic [BYTE_W-1:0] seps [6];
        seps = '{8'h00, 8'hFF, CH_SPACE, CH_QUOTE, CH_HASH, 8'h3B};
        foreach (seps[i])
        begin
            write_separator(seps[i]);
            send_byte("a");
            send_byte(seps[i]);
            send_byte(8'h00);
            send_byte(seps[i]);
            send_string("\"b\"");
            send_byte(seps[i]);
            send_byte(CH_NL);
            end_text();
        end
    endtask

    // Random text in phases, each under its own separator. In the first
    // phase the sender also stops halfway until all results are in.
    task automatic test_random_text();
        logic [BYTE_W-1:0] seps [RANDOM_PHASES];
        int unsigned       goal;
        int unsigned       halfway;
        seps = '{SEP_RESET, 8'h00, 8'hFF, CH_TAB, 8'h3B, BYTE_W'($urandom_range(0, 255))};
        foreach (seps[ph])
        begin
            write_separator(seps[ph]);
            goal    = n_useful_items + RANDOM_ITEMS / RANDOM_PHASES;
            halfway = n_useful_items + RANDOM_ITEMS / (2 * RANDOM_PHASES);
            while (n_useful_items < goal)
            begin
                if (ph == 0 && n_useful_items >= halfway && halfway != 0)
                begin
                    settle();
                    halfway = 0;
                end
                send_random_chunk();
            end
            end_text();
        end
    endtask

    // ------------------------------------------------------------------
    // Result receiver and comparison
    // ------------------------------------------------------------------

    // The receiver switches among four stall patterns at random: always ready,
    // mostly ready, ready one cycle in four, or rarely ready.
    initial
    begin
        int unsigned tick;
        int unsigned mode;
        tick = 0;
        mode = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (tick % 128 == 0)
                mode = $urandom_range(0, 3);
            case (mode)
                0: result_ch.ready <= 1'b1;
                1: result_ch.ready <= ($urandom_range(0, 3) != 0);
                2: result_ch.ready <= (tick % 4 == 0);
                default: result_ch.ready <= ($urandom_range(0, 3) == 0);
            endcase
            tick++;
        end
    end

    function automatic void compare_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            n_errors++;
            // Cap the log so a badly broken block cannot flood it.
            if (n_errors <= MAX_REPORTS)
                $error("%s: expected %0d, got %0d", name, want, got);
        end
    endfunction

    // Each accepted result request is matched against the oldest owed one.
    always @(posedge clk)
    begin
        field_result_t want;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                n_errors++;
                $error("result request with none expected: kind %0d", result_ch.kind);
            end
            else
            begin
                want = pending_results.pop_front();
                compare_field("kind", want.kind, result_ch.kind);
                compare_field("field_byte", want.field_byte, result_ch.field_byte);
                compare_field("field_length", want.field_length, result_ch.field_length);
                compare_field("row_number", want.row_number, result_ch.row_number);
                compare_field("line_number", want.line_number, result_ch.line_number);
                compare_field("column_number", want.column_number, result_ch.column_number);
                compare_field("last", want.last, result_ch.last);
            end
        end
    end

    // Guard against a hung handshake.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------

    initial
    begin
        text_ch.valid          = 1'b0;
        text_ch.in_byte        = '0;
        text_ch.end_of_input   = 1'b0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.field_separator = SEP_RESET;
        sep_model              = SEP_RESET;
        clear_parser();

        // Single reset at the start of the run.
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        bursty = 1'b1;
        test_plain_fields();
        test_quoting();
        test_comments();
        test_overflow();
        test_separator_values();
        test_random_text();

        // Let every owed result arrive, then watch for strays.
        settle();
        repeat (END_CYCLES) @(posedge clk);
        if (n_errors == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> csv_field_splitter_unit.f
+incdir+sv
sv/csvfs_pkg.sv
sv/csvfs_ifs.sv
sv/csvfs_ram.sv
sv/csvfs_dp.sv
sv/csvfs_ctrl.sv
sv/csv_field_splitter_unit.sv
verif/tb.sv
